[design/tli_pkg.sv]
// ----------------------------------------------------------------------------
// tli_pkg: shared types and constants of the table linear interpolator
// Table sizing, datapath widths, command and status codes, write request.
// ----------------------------------------------------------------------------
package tli_pkg;

  localparam int unsigned MAX_POINTS = 1024;
  localparam int unsigned IDX_W      = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned PROD_W     = 2 * DATA_W;
  localparam int unsigned DIV_STEPS  = DATA_W;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_ORDER = 2'd2
  } status_e;

  typedef struct packed {
    logic                     en;
    logic [IDX_W-1:0]         addr;
    logic signed [DATA_W-1:0] pt_time;
    logic signed [DATA_W-1:0] pt_value;
  } wr_req_t;

endpackage

[design/tli_store.sv]
// ----------------------------------------------------------------------------
// tli_store: sample point memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tli_store (
  input  logic                                 clk_i,
  input  tli_pkg::wr_req_t                     wr_i,
  input  logic [tli_pkg::IDX_W-1:0]            rd_addr_i,
  output logic signed [tli_pkg::DATA_W-1:0]    rd_time_o,
  output logic signed [tli_pkg::DATA_W-1:0]    rd_value_o
);

  logic [2*tli_pkg::DATA_W-1:0] mem [tli_pkg::MAX_POINTS];
  logic [2*tli_pkg::DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= {wr_i.pt_time, wr_i.pt_value};
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_time_o  = rd_data_q[2*tli_pkg::DATA_W-1:tli_pkg::DATA_W];
  assign rd_value_o = rd_data_q[tli_pkg::DATA_W-1:0];

endmodule

[design/tli_divider.sv]
// ----------------------------------------------------------------------------
// tli_divider: iterative unsigned divider
// Restoring division, one quotient bit per cycle; quotient must fit DATA_W.
// ----------------------------------------------------------------------------
module tli_divider (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [tli_pkg::PROD_W-1:0]        dividend_i,
  input  logic [tli_pkg::DATA_W-1:0]        divisor_i,
  output logic                              done_o,
  output logic [tli_pkg::DATA_W-1:0]        quotient_o
);

  logic                              busy_q;
  logic                              done_q;
  logic [tli_pkg::DIV_CNT_W-1:0]     cnt_q;
  logic [tli_pkg::DATA_W-1:0]        rem_q;
  logic [tli_pkg::DATA_W-1:0]        quo_q;
  logic [tli_pkg::DATA_W-1:0]        div_q;
  logic [tli_pkg::DATA_W:0]          shifted;
  logic [tli_pkg::DATA_W:0]          diff;
  logic                              fits;

  assign shifted = {rem_q, quo_q[tli_pkg::DATA_W-1]};
  assign diff    = shifted - {1'b0, div_q};
  assign fits    = shifted >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == tli_pkg::DIV_CNT_W'(tli_pkg::DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // shift one dividend bit in per cycle, subtract where the divisor fits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i[tli_pkg::PROD_W-1:tli_pkg::DATA_W];
      quo_q <= dividend_i[tli_pkg::DATA_W-1:0];
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[tli_pkg::DATA_W-1:0] : shifted[tli_pkg::DATA_W-1:0];
      quo_q <= {quo_q[tli_pkg::DATA_W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[design/table_linear_interpolator.sv]
// ----------------------------------------------------------------------------
// table_linear_interpolator: piecewise linear lookup over a point table
// Appends, clears and queries a table of signed Q16.16 (time, value) points.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one transaction per
//   command: clear, append a point, or query a time. Each transaction gives
//   exactly one output transaction (out_valid_o / out_stall_i) carrying the
//   interpolated value, the append status and the point count after it.
//   The block handles one transaction at a time; in_stall_o stays high while
//   it works. Clear, append, unused commands and queries that fall on an
//   empty table or on or outside the stored time range go from acceptance
//   straight to S_DONE, which loads the output register and raises
//   out_valid_o. An interior query runs a binary search over the point
//   memory (S_RD and S_CMP per probe, one memory read port, S <= 11 probes
//   for 1024 points), two reads for the bracketing points (S_FLO, S_FHI),
//   one multiply (S_MUL) and a shift/subtract divider (S_DGO, S_DWAIT),
//   then passes through S_DONE to the output register.
//   Reset empties the table at once; no clearing pass runs. A result held
//   by a stalled receiver sits in the output register; the next transaction
//   is still accepted and waits in its final state until that register frees.
// ----------------------------------------------------------------------------
module table_linear_interpolator (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [1:0]                           command_i,
  input  logic signed [tli_pkg::DATA_W-1:0]    sample_time_i,
  input  logic signed [tli_pkg::DATA_W-1:0]    sample_value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [tli_pkg::DATA_W-1:0]    result_value_o,
  output logic [1:0]                           status_o,
  output logic [tli_pkg::CNT_W-1:0]            point_count_o
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_RD    = 11'b000_0000_0010,
    S_CMP   = 11'b000_0000_0100,
    S_FLO   = 11'b000_0000_1000,
    S_FHI   = 11'b000_0001_0000,
    S_MUL   = 11'b000_0010_0000,
    S_DGO   = 11'b000_0100_0000,
    S_DWAIT = 11'b000_1000_0000,
    S_DONE  = 11'b001_0000_0000
  } state_e;

  state_e state_q, state_d;

  // table bookkeeping
  logic [tli_pkg::CNT_W-1:0]          count_q;
  logic signed [tli_pkg::DATA_W-1:0]  first_t_q, first_v_q, last_t_q, last_v_q;

  // query datapath
  logic signed [tli_pkg::DATA_W-1:0]  query_t_q;
  logic [tli_pkg::CNT_W-1:0]          lo_q, hi_q, mid, lo_dec;
  logic signed [tli_pkg::DATA_W-1:0]  t1_q, v1_q;
  logic [tli_pkg::DATA_W-1:0]         span_q, part_q, mag_q;
  logic                               neg_q;
  logic [tli_pkg::PROD_W-1:0]         prod_q;
  logic signed [tli_pkg::DATA_W:0]    span_w, part_w, dv_w, dv_neg, sum_w;

  // pending result and output register
  logic signed [tli_pkg::DATA_W-1:0]  res_val_q;
  logic [1:0]                         res_sts_q;
  logic                               out_valid_q;
  logic signed [tli_pkg::DATA_W-1:0]  out_val_q;
  logic [1:0]                         out_sts_q;
  logic [tli_pkg::CNT_W-1:0]          out_cnt_q;

  logic                               in_accept, out_free;
  logic                               tbl_full, bad_order, do_write, need_search;
  tli_pkg::wr_req_t                   wr_req;
  logic [tli_pkg::IDX_W-1:0]          rd_addr;
  logic signed [tli_pkg::DATA_W-1:0]  rd_time, rd_value;
  logic                               div_start, div_done;
  logic [tli_pkg::DATA_W-1:0]         quotient;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i & ~in_stall_o;
  assign out_free   = ~out_valid_q | ~out_stall_i;

  // append checks: full wins over out of order
  assign tbl_full  = count_q >= tli_pkg::CNT_W'(tli_pkg::MAX_POINTS);
  assign bad_order = (count_q != '0) && (sample_time_i < last_t_q);
  assign do_write  = in_accept && (command_i == tli_pkg::CMD_APPEND) && !tbl_full && !bad_order;

  // interior query: strictly between the first and last point times
  assign need_search = (command_i == tli_pkg::CMD_QUERY) && (count_q != '0) &&
                       (sample_time_i > first_t_q) && (sample_time_i < last_t_q);

  assign wr_req.en       = do_write;
  assign wr_req.addr     = count_q[tli_pkg::IDX_W-1:0];
  assign wr_req.pt_time  = sample_time_i;
  assign wr_req.pt_value = sample_value_i;

  // binary search midpoint; lo_q - 1 addresses the lower bracketing point
  assign mid    = lo_q + ((hi_q - lo_q) >> 1);
  assign lo_dec = lo_q - 1'b1;

  always_comb begin
    case (state_q)
      S_RD:    rd_addr = (lo_q < hi_q) ? mid[tli_pkg::IDX_W-1:0] : lo_dec[tli_pkg::IDX_W-1:0];
      S_FLO:   rd_addr = lo_q[tli_pkg::IDX_W-1:0];
      default: rd_addr = mid[tli_pkg::IDX_W-1:0];
    endcase
  end

  tli_store u_store (
    .clk_i      (clk_i),
    .wr_i       (wr_req),
    .rd_addr_i  (rd_addr),
    .rd_time_o  (rd_time),
    .rd_value_o (rd_value)
  );

  assign div_start = (state_q == S_DGO);

  tli_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (span_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // differences are taken one bit wider; span, part and |dv| fit DATA_W
  assign span_w = {rd_time[tli_pkg::DATA_W-1], rd_time} - {t1_q[tli_pkg::DATA_W-1], t1_q};
  assign part_w = {query_t_q[tli_pkg::DATA_W-1], query_t_q} - {t1_q[tli_pkg::DATA_W-1], t1_q};
  assign dv_w   = {rd_value[tli_pkg::DATA_W-1], rd_value} - {v1_q[tli_pkg::DATA_W-1], v1_q};
  assign dv_neg = -dv_w;
  assign sum_w  = neg_q ? ({v1_q[tli_pkg::DATA_W-1], v1_q} - {1'b0, quotient})
                        : ({v1_q[tli_pkg::DATA_W-1], v1_q} + {1'b0, quotient});

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_accept) state_d = need_search ? S_RD : S_DONE;
      S_RD:    state_d = (lo_q < hi_q) ? S_CMP : S_FLO;
      S_CMP:   state_d = S_RD;
      S_FLO:   state_d = S_FHI;
      S_FHI:   state_d = S_MUL;
      S_MUL:   state_d = S_DGO;
      S_DGO:   state_d = S_DWAIT;
      S_DWAIT: if (div_done) state_d = S_DONE;
      S_DONE:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control state: sequencer, point count, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_accept && (command_i == tli_pkg::CMD_CLEAR)) begin
        count_q <= '0;
      end else if (do_write) begin
        count_q <= count_q + 1'b1;
      end
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          res_val_q <= '0;
          res_sts_q <= tli_pkg::STS_OK;
          query_t_q <= sample_time_i;
          lo_q      <= '0;
          hi_q      <= count_q;
          case (command_i)
            tli_pkg::CMD_APPEND: begin
              if (tbl_full) begin
                res_sts_q <= tli_pkg::STS_FULL;
              end else if (bad_order) begin
                res_sts_q <= tli_pkg::STS_ORDER;
              end else begin
                if (count_q == '0) begin
                  first_t_q <= sample_time_i;
                  first_v_q <= sample_value_i;
                end
                last_t_q <= sample_time_i;
                last_v_q <= sample_value_i;
              end
            end
            tli_pkg::CMD_QUERY: begin
              // edge cases resolve here; interior queries overwrite later
              if (count_q == '0) begin
                res_val_q <= '0;
              end else if (sample_time_i <= first_t_q) begin
                res_val_q <= first_v_q;
              end else if (sample_time_i >= last_t_q) begin
                res_val_q <= last_v_q;
              end
            end
            default: begin
              res_val_q <= '0;
            end
          endcase
        end
      end
      S_CMP: begin
        // narrow to the first point whose time is not below the query
        if (rd_time < query_t_q) begin
          lo_q <= mid + 1'b1;
        end else begin
          hi_q <= mid;
        end
      end
      S_FLO: begin
        t1_q <= rd_time;
        v1_q <= rd_value;
      end
      S_FHI: begin
        span_q <= span_w[tli_pkg::DATA_W-1:0];
        part_q <= part_w[tli_pkg::DATA_W-1:0];
        neg_q  <= dv_w[tli_pkg::DATA_W];
        mag_q  <= dv_w[tli_pkg::DATA_W] ? dv_neg[tli_pkg::DATA_W-1:0]
                                        : dv_w[tli_pkg::DATA_W-1:0];
      end
      S_MUL: begin
        prod_q <= tli_pkg::PROD_W'(mag_q) * tli_pkg::PROD_W'(part_q);
      end
      S_DWAIT: begin
        if (div_done) begin
          res_val_q <= sum_w[tli_pkg::DATA_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // output register: load the finished transaction once the slot frees
  always_ff @(posedge clk_i) begin
    if ((state_q == S_DONE) && out_free) begin
      out_val_q <= res_val_q;
      out_sts_q <= res_sts_q;
      out_cnt_q <= count_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_val_q;
  assign status_o       = out_sts_q;
  assign point_count_o  = out_cnt_q;

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the table linear interpolator
// Drives clear, append, query and unused-command transactions through the
// valid/stall input channel. Predicts every result with a behavioral table
// model and compares each output transaction against it, field by field.
// Covers directed corner points, a deep table with a long receiver hold-off,
// and random well-formed point sets under three idle mixes.
// ----------------------------------------------------------------------------
module tb_top;

  typedef longint unsigned u64_t;

  // One output transaction: interpolated value, append status, points stored.
  typedef struct packed {
    logic signed [tli_pkg::DATA_W-1:0] value;
    tli_pkg::status_e                  status;
    logic [tli_pkg::CNT_W-1:0]         count;
  } lookup_result_t;

  localparam logic [1:0]                        CMD_UNUSED   = 2'd3;
  localparam logic signed [tli_pkg::DATA_W-1:0] Q_MIN        = 32'sh8000_0000;
  localparam logic signed [tli_pkg::DATA_W-1:0] Q_MAX        = 32'sh7FFF_FFFF;
  localparam int unsigned                       CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned                       DRAIN_CYCLES = 100;
  localparam int unsigned                       HOLD_CYCLES  = 400;
  localparam int unsigned                       MAX_REPORTS  = 10;
  localparam int unsigned                       DEEP_POINTS  = 300;
  localparam int unsigned                       RANDOM_ITEMS = 120;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              in_valid_i;
  logic                              in_stall_o;
  logic [1:0]                        command_i;
  logic signed [tli_pkg::DATA_W-1:0] sample_time_i;
  logic signed [tli_pkg::DATA_W-1:0] sample_value_i;
  logic                              out_valid_o;
  logic                              out_stall_i;
  logic signed [tli_pkg::DATA_W-1:0] result_value_o;
  logic [1:0]                        status_o;
  logic [tli_pkg::CNT_W-1:0]         point_count_o;

  table_linear_interpolator uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .sample_time_i  (sample_time_i),
    .sample_value_i (sample_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_value_o (result_value_o),
    .status_o       (status_o),
    .point_count_o  (point_count_o)
  );

  // Shadow of the point table; only entries below table_count are ever read.
  logic signed [tli_pkg::DATA_W-1:0] point_time  [tli_pkg::MAX_POINTS];
  logic signed [tli_pkg::DATA_W-1:0] point_value [tli_pkg::MAX_POINTS];
  int unsigned                       table_count;

  lookup_result_t pending_results [$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_asked;
  int unsigned hold_len;
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned item_count;
  int unsigned query_count;
  int unsigned refused_count;
  int unsigned result_count;
  int unsigned peak_count;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // --------------------------------------------------------------------------
  // Behavioral prediction
  // --------------------------------------------------------------------------

  // Value of the piecewise linear curve at time t. Search for the first point
  // not below t, then scale the value step by the exact fraction of the time
  // step and truncate the quotient toward zero.
  function automatic logic signed [tli_pkg::DATA_W-1:0] interpolate_at(
    input logic signed [tli_pkg::DATA_W-1:0] t
  );
    int unsigned lo, hi, mid;
    longint      t1, t2, v1, v2, dv;
    u64_t        span, part, mag, q;
    if (table_count == 0) return '0;
    if (t <= point_time[0]) return point_value[0];
    if (t >= point_time[table_count - 1]) return point_value[table_count - 1];
    lo = 0;
    hi = table_count;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (point_time[mid] < t) lo = mid + 1;
      else hi = mid;
    end
    // t lies strictly between the first and last times, so lo is in [1, count-1]
    t1   = point_time[lo - 1];
    t2   = point_time[lo];
    v1   = point_value[lo - 1];
    v2   = point_value[lo];
    span = u64_t'(t2 - t1);
    part = u64_t'(longint'(t) - t1);
    dv   = v2 - v1;
    mag  = (dv < 0) ? u64_t'(-dv) : u64_t'(dv);
    // both factors stay below 2^32, so the product fits in 64 bits
    q    = (mag * part) / span;
    if (dv < 0) return tli_pkg::DATA_W'(v1 - longint'(q));
    return tli_pkg::DATA_W'(v1 + longint'(q));
  endfunction

  // Advance the shadow table by one transaction and return its result.
  function automatic lookup_result_t apply_command(
    input logic [1:0]                        cmd,
    input logic signed [tli_pkg::DATA_W-1:0] t,
    input logic signed [tli_pkg::DATA_W-1:0] v
  );
    lookup_result_t r;
    r.value  = '0;
    r.status = tli_pkg::STS_OK;
    case (cmd)
      tli_pkg::CMD_CLEAR: begin
        table_count = 0;
      end
      tli_pkg::CMD_APPEND: begin
        // a full table wins over an out-of-order time
        if (table_count >= tli_pkg::MAX_POINTS) begin
          r.status = tli_pkg::STS_FULL;
        end else if (table_count > 0 && t < point_time[table_count - 1]) begin
          r.status = tli_pkg::STS_ORDER;
        end else begin
          point_time[table_count]  = t;
          point_value[table_count] = v;
          table_count++;
        end
      end
      tli_pkg::CMD_QUERY: begin
        r.value = interpolate_at(t);
      end
      default: begin
        // unused command: leave the table alone
      end
    endcase
    r.count = tli_pkg::CNT_W'(table_count);
    return r;
  endfunction

  // Query time: mostly inside the stored span with a small margin on both
  // sides, sometimes exactly on a stored time, sometimes anywhere.
  function automatic logic signed [tli_pkg::DATA_W-1:0] pick_query_time();
    int unsigned pick;
    longint      lo_t, hi_t;
    pick = $urandom_range(9);
    if (table_count == 0 || pick == 0) return $urandom;
    if (pick == 1) return point_time[$urandom_range(table_count - 1)];
    lo_t = longint'(point_time[0]) - 2;
    hi_t = longint'(point_time[table_count - 1]) + 2;
    lo_t = lo_t + longint'({$urandom, $urandom} % u64_t'(hi_t - lo_t + 1));
    if (lo_t < longint'(Q_MIN)) lo_t = Q_MIN;
    if (lo_t > longint'(Q_MAX)) lo_t = Q_MAX;
    return tli_pkg::DATA_W'(lo_t);
  endfunction

  // --------------------------------------------------------------------------
  // Input channel
  // --------------------------------------------------------------------------

  // Offer one transaction; idle at random first. Valid stays high after the
  // handshake so back-to-back transactions follow without a gap; callers
  // drop it through wait_drained once they stop sending.
  task automatic send_item(
    input logic [1:0]                        cmd,
    input logic signed [tli_pkg::DATA_W-1:0] t,
    input logic signed [tli_pkg::DATA_W-1:0] v
  );
    lookup_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    command_i      <= cmd;
    sample_time_i  <= t;
    sample_value_i <= v;
    // hold the payload until the block takes it
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    r = apply_command(cmd, t, v);
    pending_results = {pending_results, r};
    item_count++;
    if (cmd == tli_pkg::CMD_QUERY) query_count++;
    if (r.status != tli_pkg::STS_OK) refused_count++;
    if (table_count > peak_count) peak_count = table_count;
  endtask

  // Drop valid so the last transaction is not taken twice, then wait for
  // every predicted result to come out.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Output channel: random stall plus an on-demand long hold-off
  // --------------------------------------------------------------------------
  initial begin
    int unsigned hold_served;
    int unsigned hold_left;
    hold_served = 0;
    hold_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_served != hold_asked) begin
        hold_served = hold_asked;
        hold_left   = hold_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  function automatic void note_error(input string what, input lookup_result_t want);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("%0t %s: expected value %0d status %0d count %0d, got %0d %0d %0d",
               $time, what, want.value, want.status, want.count,
               result_value_o, status_o, point_count_o);
  endfunction

  // Compare each output transaction with the oldest prediction.
  always @(posedge clk_i) begin
    lookup_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      result_count++;
      if (pending_results.size() == 0) begin
        want = '0;
        note_error("result with nothing pending", want);
      end else begin
        want = pending_results.pop_front();
        if (result_value_o !== want.value || status_o !== want.status ||
            point_count_o !== want.count)
          note_error("result mismatch", want);
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Corner points: empty table, single point, the widest time and value span,
  // equal times, out-of-order appends, and the unused command.
  task automatic test_directed();
    send_item(tli_pkg::CMD_QUERY, 0, 0);
    send_item(CMD_UNUSED, $urandom, $urandom);
    send_item(tli_pkg::CMD_CLEAR, $urandom, $urandom);
    send_item(tli_pkg::CMD_APPEND, 7, 42);
    send_item(tli_pkg::CMD_QUERY, 6, 0);
    send_item(tli_pkg::CMD_QUERY, 8, 0);
    send_item(tli_pkg::CMD_APPEND, 3, 1);
    send_item(tli_pkg::CMD_CLEAR, 0, 0);
    // full-range segment: largest span and largest value step
    send_item(tli_pkg::CMD_APPEND, Q_MIN, Q_MAX);
    send_item(tli_pkg::CMD_APPEND, Q_MAX, Q_MIN);
    send_item(tli_pkg::CMD_QUERY, Q_MIN, 0);
    send_item(tli_pkg::CMD_QUERY, Q_MAX, 0);
    send_item(tli_pkg::CMD_QUERY, 0, 0);
    send_item(tli_pkg::CMD_QUERY, Q_MAX - 1, 0);
    send_item(tli_pkg::CMD_APPEND, Q_MAX, 7);
    send_item(tli_pkg::CMD_APPEND, 0, 0);
    send_item(tli_pkg::CMD_CLEAR, 0, 0);
    // duplicate time at the head of the table
    send_item(tli_pkg::CMD_APPEND, 100, 5);
    send_item(tli_pkg::CMD_APPEND, 100, 9);
    send_item(tli_pkg::CMD_APPEND, 200, -3);
    send_item(tli_pkg::CMD_QUERY, 100, 0);
    send_item(tli_pkg::CMD_QUERY, 150, 0);
    send_item(tli_pkg::CMD_QUERY, 199, 0);
    send_item(tli_pkg::CMD_QUERY, 201, 0);
    send_item(CMD_UNUSED, Q_MAX, -1);
    wait_drained();
  endtask

  // Build a deep table so the search runs many probes, then append at the top
  // time and try an out-of-order time. Leave the table filled for the next test.
  task automatic test_deep_table();
    longint nt;
    send_item(tli_pkg::CMD_CLEAR, 0, 0);
    nt = longint'(Q_MIN) + longint'($urandom_range(255));
    repeat (DEEP_POINTS) begin
      send_item(tli_pkg::CMD_APPEND, tli_pkg::DATA_W'(nt), $urandom);
      // steps stay small enough that the whole table never wraps
      if ($urandom_range(9) != 0) nt = nt + longint'($urandom_range(1, 1 << 21));
    end
    send_item(tli_pkg::CMD_APPEND, Q_MAX, $urandom);
    send_item(tli_pkg::CMD_APPEND, Q_MIN, $urandom);
    repeat (6) send_item(tli_pkg::CMD_QUERY, pick_query_time(), $urandom);
    wait_drained();
  endtask

  // Hold the receiver off while queries keep coming: the output register
  // fills, the next transaction parks, and the input stalls.
  task automatic test_backpressure();
    hold_len = HOLD_CYCLES;
    hold_asked++;
    repeat (12) send_item(tli_pkg::CMD_QUERY, pick_query_time(), $urandom);
    wait_drained();
  endtask

  // Mostly well-formed point sets of random size with queries in between;
  // the rest is clears, out-of-order appends and unused commands.
  task automatic test_random(input int unsigned n_items);
    int unsigned                       pick, cap;
    longint                            nt, last;
    logic signed [tli_pkg::DATA_W-1:0] t;
    cap = $urandom_range(2, 48);
    repeat (n_items) begin
      pick = $urandom_range(99);
      last = (table_count > 0) ? longint'(point_time[table_count - 1]) : 0;
      if (pick < 3 || (table_count >= cap && pick < 40)) begin
        send_item(tli_pkg::CMD_CLEAR, $urandom, $urandom);
        cap = $urandom_range(2, 48);
      end else if (pick < 5) begin
        send_item(CMD_UNUSED, $urandom, $urandom);
      end else if (pick < 10 && table_count > 0 && last != longint'(Q_MIN)) begin
        nt = last - 1 - longint'($urandom_range(1000));
        if (nt < longint'(Q_MIN)) nt = Q_MIN;
        send_item(tli_pkg::CMD_APPEND, tli_pkg::DATA_W'(nt), $urandom);
      end else if (pick < 50) begin
        if (table_count == 0) begin
          t  = $urandom;
          nt = ($urandom_range(1) == 0) ? longint'(t)
                                         : longint'($urandom_range(1 << 20)) - (1 << 19);
        end else begin
          case ($urandom_range(3))
            0:       nt = last + longint'($urandom_range(3));
            1, 2:    nt = last + longint'($urandom_range(1 << 20));
            default: nt = last + longint'($urandom);
          endcase
          // saturate: equal times at the top are still in order
          if (nt > longint'(Q_MAX)) nt = Q_MAX;
        end
        send_item(tli_pkg::CMD_APPEND, tli_pkg::DATA_W'(nt), $urandom);
      end else begin
        send_item(tli_pkg::CMD_QUERY, pick_query_time(), $urandom);
      end
    end
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    command_i      = tli_pkg::CMD_CLEAR;
    sample_time_i  = '0;
    sample_value_i = '0;
    table_count    = 0;
    hold_asked     = 0;
    hold_len       = 0;
    error_count    = 0;
    cycle_count    = 0;
    item_count     = 0;
    query_count    = 0;
    refused_count  = 0;
    result_count   = 0;
    peak_count     = 0;
    send_idle_pct  = 38;
    recv_idle_pct  = 72;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_deep_table();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();

    send_idle_pct = 38;
    recv_idle_pct = 72;
    test_random(RANDOM_ITEMS);
    send_idle_pct = 72;
    recv_idle_pct = 38;
    test_random(RANDOM_ITEMS);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(RANDOM_ITEMS);

    // let any stray result surface before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d transactions (%0d queries, %0d refused appends), %0d results checked,",
             item_count, query_count, refused_count, result_count);
    $display("table filled up to %0d points, three idle mixes plus a long receiver hold-off.",
             peak_count);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
